@@ rtl/dtps_pkg.sv @@
// dtps_pkg: shared types, codes and defaults for the depth-tested pixel store.
// No dependencies; used by dtps_cfg, the top level and dtps_chk.
package dtps_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	// frame dimension width, enough for the largest built maximum (4096)
	localparam int DIM_W   = 13;
	localparam int REG_W   = 9;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [1:0] FUNC_FILL  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_DEPTH = 2'd2;

	localparam logic [1:0] ST_STORED     = 2'd0;
	localparam logic [1:0] ST_OUTSIDE    = 2'd1;
	localparam logic [1:0] ST_DEPTH_FAIL = 2'd2;
	localparam logic [1:0] ST_FILL_DONE  = 2'd3;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [REG_W-1:0] FRAME_DIM_RST = 9'd256;

	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} dims_t;

endpackage

@@ rtl/dtps_if.sv @@
// dtps_if: request and response channel interfaces (valid/ready handshake).
// Depends on nothing; payload follows the pixel request and response fields.
interface dtps_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  func;
	logic signed [15:0] col;
	logic signed [15:0] row;
	logic signed [31:0] depth;
	logic        [31:0] pixel_color;

	modport source (output valid, func, col, row, depth, pixel_color, input ready);
	modport sink   (input valid, func, col, row, depth, pixel_color, output ready);
endinterface

interface dtps_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] address;

	modport source (output valid, status, address, input ready);
	modport sink   (input valid, status, address, output ready);
endinterface

@@ rtl/dtps_ram.sv @@
// dtps_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module dtps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/dtps_cfg.sv @@
// dtps_cfg: APB register file for frame width/height; dims clamped to 1..built maximum.
// Depends on dtps_pkg.
module dtps_cfg #(
	parameter int MAX_WIDTH  = dtps_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dtps_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dtps_pkg::PADDR_W-1:0]  paddr,
	input  logic [dtps_pkg::PDATA_W-1:0]  pwdata,
	output logic [dtps_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output dtps_pkg::dims_t               dims
);

	localparam int DW = dtps_pkg::DIM_W;

	logic [dtps_pkg::REG_W-1:0] frame_width_q;
	logic [dtps_pkg::REG_W-1:0] frame_height_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= dtps_pkg::FRAME_DIM_RST;
			frame_height_q <= dtps_pkg::FRAME_DIM_RST;
		end else if (wr_en) begin
			case (paddr[2])
				dtps_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[dtps_pkg::REG_W-1:0];
				dtps_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[dtps_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			dtps_pkg::REG_FRAME_WIDTH:
				prdata = dtps_pkg::PDATA_W'(frame_width_q);
			default:
				prdata = dtps_pkg::PDATA_W'(frame_height_q);
		endcase
	end

	// on dims, zero becomes one and anything above the built maximum saturates
	always_comb begin
		logic [DW-1:0] wr;
		logic [DW-1:0] hr;
		wr = DW'(frame_width_q);
		hr = DW'(frame_height_q);
		if (wr == '0)
			dims.w = DW'(1);
		else if (wr > DW'(MAX_WIDTH))
			dims.w = DW'(MAX_WIDTH);
		else
			dims.w = wr;
		if (hr == '0)
			dims.h = DW'(1);
		else if (hr > DW'(MAX_HEIGHT))
			dims.h = DW'(MAX_HEIGHT);
		else
			dims.h = hr;
	end

endmodule

@@ rtl/depth_tested_pixel_store.sv @@
// Depth-tested pixel store: color and depth stores in synchronous RAM.
// Write and depth requests step through S_ADDR, S_READ (depth read) and S_RES (compare,
// write, response registered once the response slot is free); one request at a time.
// Fill: S_ADDR, S_FILL (frame_width*frame_height entries, one entry/cycle), then S_RES.
// Reset: asynchronous, active low; the depth store is then cleared one entry
// per cycle over all MAX_WIDTH*MAX_HEIGHT entries, with no request accepted meanwhile.
module depth_tested_pixel_store #(
	parameter int MAX_WIDTH  = dtps_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dtps_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dtps_pkg::PADDR_W-1:0]  paddr,
	input  logic [dtps_pkg::PDATA_W-1:0]  pwdata,
	output logic [dtps_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	dtps_req_if.sink                      req,
	dtps_rsp_if.source                    rsp
);

	localparam int DW = dtps_pkg::DIM_W;
	localparam int ST = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = (ST > 1) ? $clog2(ST) : 1;
	localparam int PW = 2 * DW;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_ADDR  = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_RES   = 3'd4;
	localparam logic [2:0] S_FILL  = 3'd5;

	dtps_pkg::dims_t dims;

	logic [2:0]        state_q;
	logic [AW-1:0]     cnt_q;
	logic [1:0]        func_q;
	logic [15:0]       col_q;
	logic [15:0]       row_q;
	logic signed [31:0] depth_q;
	logic [31:0]       color_q;
	logic [PW-1:0]     sum_q;
	logic              inb_q;

	logic              rsp_valid_q;
	logic [1:0]        status_q;
	logic [15:0]       address_q;

	logic              slot_free;
	logic              inb;
	logic [DW-1:0]     op_a;
	logic [PW-1:0]     sum;

	logic              d_we;
	logic [AW-1:0]     d_waddr;
	logic [31:0]       d_wdata;
	logic [31:0]       d_rdata;
	logic              c_we;
	logic [AW-1:0]     c_waddr;

	logic              res_write;
	logic [1:0]        res_status;

	dtps_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.dims    (dims)
	);

	assign req.ready = (state_q == S_IDLE);
	assign slot_free = !rsp_valid_q || rsp.ready;

	// bounds check and address; row 0 is the bottom line
	always_comb begin
		inb = !col_q[15] && !row_q[15]
			&& (col_q < 16'(dims.w)) && (row_q < 16'(dims.h));
		if (func_q == dtps_pkg::FUNC_FILL)
			op_a = dims.h;
		else
			op_a = dims.h - DW'(1) - row_q[DW-1:0];
		sum = PW'(op_a) * PW'(dims.w);
		if (func_q != dtps_pkg::FUNC_FILL)
			sum = sum + PW'(col_q[DW-1:0]);
	end

	always_comb begin
		res_write  = 1'b0;
		res_status = dtps_pkg::ST_OUTSIDE;
		if (func_q == dtps_pkg::FUNC_FILL) begin
			res_status = dtps_pkg::ST_FILL_DONE;
		end else if ((func_q inside {dtps_pkg::FUNC_WRITE, dtps_pkg::FUNC_DEPTH}) && inb_q) begin
			if (func_q == dtps_pkg::FUNC_DEPTH && $signed(d_rdata) > depth_q) begin
				res_status = dtps_pkg::ST_DEPTH_FAIL;
			end else begin
				res_status = dtps_pkg::ST_STORED;
				res_write  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.ready && !(state_q == S_RES && slot_free))
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(ST - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid)
						state_q <= S_ADDR;
				end
				S_ADDR: begin
					cnt_q <= '0;
					if (func_q == dtps_pkg::FUNC_FILL)
						state_q <= S_FILL;
					else
						state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_RES;
				end
				S_FILL: begin
					cnt_q <= cnt_q + AW'(1);
					if (PW'(cnt_q) + PW'(1) == sum_q)
						state_q <= S_RES;
				end
				S_RES: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q  <= req.func;
			col_q   <= req.col;
			row_q   <= req.row;
			depth_q <= req.depth;
			color_q <= req.pixel_color;
		end
		if (state_q == S_ADDR) begin
			sum_q <= sum;
			inb_q <= inb;
		end
		if (state_q == S_RES && slot_free) begin
			status_q  <= res_status;
			address_q <= res_write ? 16'(sum_q[AW-1:0]) : 16'd0;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = status_q;
	assign rsp.address = address_q;

	always_comb begin
		d_we    = 1'b0;
		d_waddr = sum_q[AW-1:0];
		d_wdata = depth_q;
		c_we    = 1'b0;
		c_waddr = sum_q[AW-1:0];
		if (state_q == S_CLEAR) begin
			d_we    = 1'b1;
			d_waddr = cnt_q;
			d_wdata = '0;
		end else if (state_q == S_FILL) begin
			c_we    = 1'b1;
			c_waddr = cnt_q;
		end else if (state_q == S_RES && slot_free && res_write) begin
			c_we = 1'b1;
			d_we = (func_q == dtps_pkg::FUNC_DEPTH);
		end
	end

	dtps_ram #(
		.WIDTH (32),
		.DEPTH (ST)
	) u_depth_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (state_q == S_READ),
		.raddr (sum_q[AW-1:0]),
		.rdata (d_rdata)
	);

	dtps_ram #(
		.WIDTH (32),
		.DEPTH (ST)
	) u_color_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (color_q),
		.re    (1'b0),
		.raddr (c_waddr),
		.rdata ()
	);

endmodule

@@ rtl/dtps_chk.sv @@
// dtps_chk: port-level assertions for depth_tested_pixel_store, with its bind.
// Depends on dtps_pkg and the top level's ports.
module dtps_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [15:0] rsp_address
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one still in progress");

	a_fill_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == dtps_pkg::ST_FILL_DONE |-> rsp_address == 16'd0)
		else $error("fill response carries nonzero address");

	a_drop_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == dtps_pkg::ST_OUTSIDE
			|| rsp_status == dtps_pkg::ST_DEPTH_FAIL) |-> rsp_address == 16'd0)
		else $error("dropped write reports an address");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_address))
		else $error("stalled response changed");

endmodule

bind depth_tested_pixel_store dtps_chk u_dtps_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_address (rsp.address)
);
